### rtl/core/cfp_pkg.sv
// Shared types, constants and the CRC-8 byte step for the frame parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package cfp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NACK_COMMAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_ERROR_CODE = 2'd2;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Byte positions and the fixed length field of a generated NACK frame.
  localparam logic [7:0] NACK_POS_START = 8'd0;
  localparam logic [7:0] NACK_POS_CMD   = 8'd1;
  localparam logic [7:0] NACK_POS_LEN   = 8'd2;
  localparam logic [7:0] NACK_POS_FCMD  = 8'd3;
  localparam logic [7:0] NACK_POS_ERR   = 8'd4;
  localparam logic [7:0] NACK_POS_CRC   = 8'd5;
  localparam logic [7:0] NACK_LEN       = 8'd2;

  typedef enum logic [2:0] {
    S_WAIT,
    S_CMD,
    S_LEN,
    S_PAY,
    S_CRC,
    S_FILL,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_NACK    = 2'd2
  } kind_t;

  typedef struct packed {
    logic ld_cmd;
    logic ld_len;
    logic ld_pay;
    logic emit_start;
    logic fill;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic len_zero;
    logic pay_done;
    logic last;
  } sts_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/cfp_rx_if.sv
// Receive byte channel: valid/ready handshake with one 8-bit byte.
// No dependencies.
interface cfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/cfp_res_if.sv
// Result channel of the frame parser: valid/ready handshake plus result fields.
// No dependencies.
interface cfp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] frame_command;
  logic [7:0] frame_length;
  logic [4:0] byte_index;
  logic [7:0] data_byte;
  logic       truncated;
  logic       last;

  modport source (output valid, output out_kind, output frame_command,
                  output frame_length, output byte_index, output data_byte,
                  output truncated, output last, input ready);
  modport sink   (input valid, input out_kind, input frame_command,
                  input frame_length, input byte_index, input data_byte,
                  input truncated, input last, output ready);
endinterface

### rtl/core/cfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cfp_ctrl.sv
// Frame parser controller: sequences the parse states and the result burst.
// Depends on cfp_pkg; drives the datapath through cfp_pkg::cmd_t.
module cfp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cfp_pkg::sts_t sts,
  output cfp_pkg::cmd_t cmd
);

  cfp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfp_pkg::S_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cfp_pkg::S_WAIT: begin
        if (in_valid && sts.is_start) state_next = cfp_pkg::S_CMD;
      end
      cfp_pkg::S_CMD: begin
        if (in_valid) state_next = cfp_pkg::S_LEN;
      end
      cfp_pkg::S_LEN: begin
        if (in_valid) state_next = sts.len_zero ? cfp_pkg::S_CRC : cfp_pkg::S_PAY;
      end
      cfp_pkg::S_PAY: begin
        if (in_valid && sts.pay_done) state_next = cfp_pkg::S_CRC;
      end
      cfp_pkg::S_CRC: begin
        if (in_valid) state_next = cfp_pkg::S_FILL;
      end
      cfp_pkg::S_FILL: begin
        state_next = cfp_pkg::S_SEND;
      end
      cfp_pkg::S_SEND: begin
        if (out_ready) state_next = sts.last ? cfp_pkg::S_WAIT : cfp_pkg::S_FILL;
      end
      default: begin
        state_next = cfp_pkg::S_WAIT;
      end
    endcase
  end

  // Ready is high in every parse state, so a valid byte there is a transfer.
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    case (state)
      cfp_pkg::S_WAIT: begin
        in_ready = 1'b1;
      end
      cfp_pkg::S_CMD: begin
        in_ready   = 1'b1;
        cmd.ld_cmd = in_valid;
      end
      cfp_pkg::S_LEN: begin
        in_ready   = 1'b1;
        cmd.ld_len = in_valid;
      end
      cfp_pkg::S_PAY: begin
        in_ready   = 1'b1;
        cmd.ld_pay = in_valid;
      end
      cfp_pkg::S_CRC: begin
        in_ready       = 1'b1;
        cmd.emit_start = in_valid;
      end
      cfp_pkg::S_FILL: begin
        cmd.fill = 1'b1;
      end
      cfp_pkg::S_SEND: begin
        out_valid = 1'b1;
        cmd.step  = out_ready && !sts.last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/cfp_dp.sv
// Frame parser datapath: config registers, held fields, running CRC, payload
// buffer and the result register. Depends on cfp_pkg and cfp_ram.
module cfp_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic [7:0]                    rx_byte,
  input  cfp_pkg::cmd_t                 cmd,
  output cfp_pkg::sts_t                 sts,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    frame_command,
  output logic [7:0]                    frame_length,
  output logic [4:0]                    byte_index,
  output logic [7:0]                    data_byte,
  output logic                          truncated,
  output logic                          last
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [7:0]      start_byte;
  logic [7:0]      nack_command;
  logic [7:0]      crc_error_code;
  logic [7:0]      held_command;
  logic [7:0]      held_length;
  logic [7:0]      payload_count;
  logic [7:0]      running_crc;
  cfp_pkg::kind_t  mode;
  logic [AW-1:0]   idx;
  cfp_pkg::kind_t  out_kind_r;
  logic [4:0]      out_idx;
  logic [7:0]      out_data;
  logic            out_trunc;
  logic            out_last;

  logic            trunc;
  logic [7:0]      burst_len;
  logic [7:0]      idx8;
  logic            last_c;
  logic [7:0]      nack_byte;
  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  assign trunc     = held_length > MAX_LEN;
  assign burst_len = trunc ? MAX_LEN : held_length;
  assign idx8      = 8'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= 8'hAA;
      nack_command   <= 8'h00;
      crc_error_code <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        cfp_pkg::REG_START_BYTE:     start_byte     <= cfg_data;
        cfp_pkg::REG_NACK_COMMAND:   nack_command   <= cfg_data;
        cfp_pkg::REG_CRC_ERROR_CODE: crc_error_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bytes of the NACK frame, by position.
  always_comb begin
    case (idx8)
      cfp_pkg::NACK_POS_START: nack_byte = start_byte;
      cfp_pkg::NACK_POS_CMD:   nack_byte = nack_command;
      cfp_pkg::NACK_POS_LEN:   nack_byte = cfp_pkg::NACK_LEN;
      cfp_pkg::NACK_POS_FCMD:  nack_byte = held_command;
      cfp_pkg::NACK_POS_ERR:   nack_byte = crc_error_code;
      default:                 nack_byte = running_crc;
    endcase
  end

  always_comb begin
    case (mode)
      cfp_pkg::KIND_PAYLOAD: last_c = (idx8 + 8'd1) == burst_len;
      cfp_pkg::KIND_EMPTY:   last_c = 1'b1;
      default:               last_c = idx8 == cfp_pkg::NACK_POS_CRC;
    endcase
  end

  // On a mismatch the running CRC is reused to build the NACK trailer: it
  // restarts at zero and takes the NACK bytes between the start and CRC bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_command  <= 8'h00;
      held_length   <= 8'h00;
      payload_count <= 8'h00;
      running_crc   <= cfp_pkg::CRC_INIT;
      mode          <= cfp_pkg::KIND_PAYLOAD;
      idx           <= '0;
    end else begin
      if (cmd.ld_cmd) begin
        held_command <= rx_byte;
        running_crc  <= cfp_pkg::crc8_step(cfp_pkg::CRC_INIT, rx_byte);
      end
      if (cmd.ld_len) begin
        held_length   <= rx_byte;
        payload_count <= 8'h00;
        running_crc   <= cfp_pkg::crc8_step(running_crc, rx_byte);
      end
      if (cmd.ld_pay) begin
        payload_count <= 8'(payload_count + 8'd1);
        running_crc   <= cfp_pkg::crc8_step(running_crc, rx_byte);
      end
      if (cmd.emit_start) begin
        idx <= '0;
        if (rx_byte == running_crc) begin
          mode <= (held_length == 8'h00) ? cfp_pkg::KIND_EMPTY : cfp_pkg::KIND_PAYLOAD;
        end else begin
          mode        <= cfp_pkg::KIND_NACK;
          running_crc <= cfp_pkg::CRC_INIT;
        end
      end
      if (cmd.fill && mode == cfp_pkg::KIND_NACK &&
          idx8 != cfp_pkg::NACK_POS_START && idx8 != cfp_pkg::NACK_POS_CRC) begin
        running_crc <= cfp_pkg::crc8_step(running_crc, nack_byte);
      end
      if (cmd.step) begin
        idx <= AW'(idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      out_kind_r <= mode;
      out_idx    <= idx8[4:0];
      out_last   <= last_c;
      case (mode)
        cfp_pkg::KIND_PAYLOAD: begin
          out_data  <= ram_rdata;
          out_trunc <= trunc;
        end
        cfp_pkg::KIND_EMPTY: begin
          out_data  <= 8'h00;
          out_trunc <= 1'b0;
        end
        default: begin
          out_data  <= nack_byte;
          out_trunc <= trunc;
        end
      endcase
    end
  end

  assign ram_we    = cmd.ld_pay && (payload_count < MAX_LEN);
  assign ram_re    = cmd.emit_start || cmd.step;
  assign ram_raddr = cmd.emit_start ? '0 : AW'(idx + 1'b1);

  cfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (payload_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.is_start = rx_byte == start_byte;
  assign sts.len_zero = rx_byte == 8'h00;
  assign sts.pay_done = 8'(payload_count + 8'd1) >= held_length;
  assign sts.last     = out_last;

  assign out_kind      = out_kind_r;
  assign frame_command = held_command;
  assign frame_length  = held_length;
  assign byte_index    = out_idx;
  assign data_byte     = out_data;
  assign truncated     = out_trunc;
  assign last          = out_last;

endmodule

### rtl/core/crc8_frame_parser.sv
// Receive-side frame parser (start, command, length, payload, CRC-8 poly 0x31).
// While a frame is being parsed one byte is taken per cycle that the source offers
// one. After the CRC byte it stops taking bytes and emits its results, each by a
// payload buffer read and a load of the output register, plus any wait while the
// result sink holds ready low; then it hunts for the next start byte. A good
// frame yields its stored payload bytes (at most MAX_PAYLOAD, flagged truncated
// if the length was larger) or one empty-frame result; a bad CRC yields a
// six-byte NACK frame. The payload buffer needs no clearing after reset.
// Depends on cfp_pkg, cfp_rx_if, cfp_res_if, cfp_ctrl and cfp_dp.
module crc8_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  cfp_rx_if.sink                        rx,
  cfp_res_if.source                     res
);

  cfp_pkg::cmd_t cmd;
  cfp_pkg::sts_t sts;

  cfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx.rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_kind      (res.out_kind),
    .frame_command (res.frame_command),
    .frame_length  (res.frame_length),
    .byte_index    (res.byte_index),
    .data_byte     (res.data_byte),
    .truncated     (res.truncated),
    .last          (res.last)
  );

  // The parser never takes a byte while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && res.valid))
    else $error("input ready while a result is pending");

  // Once the final result of a burst is taken, the parser hunts again.
  a_resume: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.last) |=> rx.ready)
    else $error("parser did not resume after final result");

  // An empty-frame result stands alone and carries a zero byte.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.out_kind == cfp_pkg::KIND_EMPTY) |->
      (res.last && res.data_byte == 8'h00 && res.byte_index == 5'd0))
    else $error("malformed empty-frame result");

  // The NACK length field is fixed.
  a_nack_len: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.out_kind == cfp_pkg::KIND_NACK &&
     res.byte_index == 5'(cfp_pkg::NACK_POS_LEN)) |-> res.data_byte == cfp_pkg::NACK_LEN)
    else $error("NACK length byte wrong");

endmodule
